// ----- rtl/b51_pkg.sv -----
// Shared types, constants and the symbol lookup for the base-51 ID encoder.
// No dependencies; every other file in rtl/ imports this package.
package b51_pkg;

    // Base-51 digit arithmetic.
    localparam int ALPHA_BASE  = 51;
    localparam int DIGIT_W     = 6;
    localparam int MAX_SYMBOLS = 6;

    // Result word fields.
    localparam int SYMBOL_W = 7;
    localparam int LEN_W    = 3;

    // Buffer capacity register.
    localparam int               CAP_W     = 8;
    localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

    // Alphabet, first character in the top byte.
    localparam logic [8*ALPHA_BASE-1:0] ALPHABET =
        "23456789bcdfghjkmnpqrstvwxyzBCDFGHJKLMNPQRSTVWXYZ-_";

    // Operation of one digit cell in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DOUBLE
    } cell_mode_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EVAL,
        ST_EMIT
    } fsm_state_t;

    // ASCII code of the character for one base-51 digit.
    function automatic logic [SYMBOL_W-1:0] symbol_of(input logic [DIGIT_W-1:0] d);
        logic [SYMBOL_W-1:0] sym;
        sym = '0;
        if (int'(d) < ALPHA_BASE) begin
            sym = ALPHABET[8*(ALPHA_BASE-1-int'(d)) +: SYMBOL_W];
        end
        return sym;
    endfunction

endpackage

// ----- rtl/base51_id_to_short_string_core.sv -----
// Top level of the base-51 ID to short string encoder: sequencer, digit chain, output word.
// Depends on b51_pkg and b51_cell.
//
//  Channel  | Direction | Handshake          | Contents
//  s_       | in        | s_tvalid/s_tready  | s_tdata: id_value
//  m_       | out       | m_tvalid/m_tready  | m_tdata: symbol, string_length; m_tuser: flags
//  cfg_     | in        | cfg_wr_en          | cfg_wr_data: buffer_capacity
//
// An ID is loaded, its magnitude converted, its digit count evaluated and n = 1..6 result
// words emitted; the digit chain takes one magnitude bit per cycle, most significant first.
// One ID is in work at a time; s_tready is high while the sequencer is idle, even when the
// last result word still waits in the output register.
// A stall on m_tready holds the output register and the sequencer; no word is dropped.
// aresetn is synchronous and active low; buffer_capacity resets to 100.
module base51_id_to_short_string_core
    import b51_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration
    input  logic                                cfg_wr_en,
    input  logic [CAP_W-1:0]                    cfg_wr_data,   // buffer_capacity
    // Input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,       // id_value
    // Result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,       // symbol, string_length
    output logic [1:0]                          m_tuser,       // has_symbol, failed
    output logic                                m_tlast
);

    // Enough digit cells for the largest positive value, ceil((W-1) / log2(51)).
    localparam int CELLS = ((VALUE_WIDTH-1)*1000 + 5671) / 5672;
    localparam int CNT_W = $clog2(CELLS+1);
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int BIT_W = $clog2(VALUE_WIDTH);
    localparam int MAG_W = VALUE_WIDTH - 1;

    fsm_state_t state_reg, state_next;

    logic [CAP_W-1:0]    cap_reg;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [BIT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                fail_reg, fail_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    logic                out_valid_reg, out_valid_next;
    logic [SYMBOL_W-1:0] out_symbol_reg, out_symbol_next;
    logic                out_has_reg, out_has_next;
    logic [LEN_W-1:0]    out_len_reg, out_len_next;
    logic                out_fail_reg, out_fail_next;
    logic                out_last_reg, out_last_next;

    cell_mode_t          cell_mode;
    logic [DIGIT_W-1:0]  digit [CELLS];
    logic                carry [CELLS];
    logic [CNT_W-1:0]    digit_count;
    logic                load_out;

    // Digit chain: cell 0 holds the least significant digit and takes the next magnitude bit.
    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        b51_cell u_cell (
            .aclk      (aclk),
            .mode      (cell_mode),
            .carry_in  ((k == 0) ? mag_reg[MAG_W-1] : carry[(k == 0) ? 0 : k-1]),
            .carry_out (carry[k]),
            .digit     (digit[k])
        );
    end

    // Number of significant digits: one past the highest nonzero cell.
    always_comb begin
        digit_count = '0;
        for (int k = 0; k < CELLS; k++) begin
            if (digit[k] != '0) begin
                digit_count = CNT_W'(k + 1);
            end
        end
    end

    // Buffer capacity register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Sequencer state and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge aclk) begin
        mag_reg        <= mag_next;
        bit_cnt_reg    <= bit_cnt_next;
        len_reg        <= len_next;
        fail_reg       <= fail_next;
        idx_reg        <= idx_next;
        out_symbol_reg <= out_symbol_next;
        out_has_reg    <= out_has_next;
        out_len_reg    <= out_len_next;
        out_fail_reg   <= out_fail_next;
        out_last_reg   <= out_last_next;
    end

    // Next state, cell control and result words.
    always_comb begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        bit_cnt_next    = bit_cnt_reg;
        len_next        = len_reg;
        fail_next       = fail_reg;
        idx_next        = idx_reg;
        cell_mode       = CELL_HOLD;
        s_tready        = 1'b0;
        out_symbol_next = out_symbol_reg;
        out_has_next    = out_has_reg;
        out_len_next    = out_len_reg;
        out_fail_next   = out_fail_reg;
        out_last_next   = out_last_reg;
        load_out        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    // A negative ID converts as zero and gives an empty string (a failure if capacity is zero).
                    mag_next     = s_tdata[VALUE_WIDTH-1] ? '0 : s_tdata[MAG_W-1:0];
                    bit_cnt_next = BIT_W'(MAG_W);
                    cell_mode    = CELL_CLEAR;
                    state_next   = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                cell_mode    = CELL_DOUBLE;
                mag_next     = {mag_reg[MAG_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_W'(1);
                if (bit_cnt_reg == BIT_W'(1)) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                // The string needs room for the terminator too, so the count must stay
                // below the capacity; more than six digits also fails.
                fail_next  = (CAP_W'(digit_count) >= cap_reg) ||
                             (CAP_W'(digit_count) > CAP_W'(MAX_SYMBOLS));
                len_next   = LEN_W'(digit_count);
                idx_next   = IDX_W'(digit_count - CNT_W'(1));
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    load_out = 1'b1;
                    if (fail_reg || len_reg == '0) begin
                        out_symbol_next = '0;
                        out_has_next    = 1'b0;
                        out_len_next    = '0;
                        out_fail_next   = fail_reg;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        out_symbol_next = symbol_of(digit[idx_reg]);
                        out_has_next    = 1'b1;
                        out_len_next    = len_reg;
                        out_fail_next   = 1'b0;
                        out_last_next   = (idx_reg == '0);
                        idx_next        = idx_reg - IDX_W'(1);
                        if (idx_reg == '0) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Output register: filled by the sequencer, emptied by the consumer.
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_len_reg, out_symbol_reg};
    assign m_tuser  = {out_fail_reg, out_has_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/b51_cell.sv -----
// One base-51 digit cell of the binary to base-51 conversion chain.
// Depends on b51_pkg for the digit width and the cell operation codes.
module b51_cell
    import b51_pkg::*;
(
    input  logic               aclk,
    input  cell_mode_t         mode,
    input  logic               carry_in,
    output logic               carry_out,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W:0]   sum;
    logic [DIGIT_W:0]   reduced;

    // Doubling the digit and adding the carry from below stays under twice the base,
    // so one compare and subtract brings it back into range.
    assign sum       = {digit_reg, carry_in};
    assign carry_out = (sum >= (DIGIT_W+1)'(ALPHA_BASE));
    assign reduced   = sum - (DIGIT_W+1)'(ALPHA_BASE);

    always_comb begin
        case (mode)
            CELL_CLEAR:  digit_next = '0;
            CELL_DOUBLE: digit_next = carry_out ? reduced[DIGIT_W-1:0] : sum[DIGIT_W-1:0];
            default:     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

// ----- sim/tb_base51_id_to_short_string_core.sv -----
// Self-checking testbench for base51_id_to_short_string_core: directed table, then random IDs.
// Depends on b51_pkg and the RTL in rtl/; expected words come from a predictor in this file.
`timescale 1ns / 100ps

module tb_base51_id_to_short_string_core;
    import b51_pkg::*;

    localparam int ID_W          = 32;
    localparam int RADIX         = 51;
    localparam int MAX_DIGITS    = 6;
    localparam int DIGIT_SLOTS   = 16;
    localparam int HOLD_CYCLES   = 200;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 48;
    localparam int RAND_PHASES   = 5;
    localparam int PHASE_ITEMS   = 22;

    // One result word as the block should emit it.
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                has_symbol;
        logic [LEN_W-1:0]    str_len;
        logic                failed;
        logic                last;
    } enc_word_t;

    // One row of the directed table; typed rows carry their single expected word.
    typedef struct {
        logic [CAP_W-1:0] cap;
        logic [ID_W-1:0]  id;
        bit               typed;
        enc_word_t        word;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [CAP_W-1:0]    cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [ID_W-1:0]     s_tdata;      // id_value
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;      // symbol [6:0], string_length [9:7], zeros above
    logic [1:0]          m_tuser;      // has_symbol [0], failed [1]
    logic                m_tlast;

    string            symbol_set = "23456789bcdfghjkmnpqrstvwxyzBCDFGHJKLMNPQRSTVWXYZ-_";
    logic [CAP_W-1:0] capacity_shadow;
    enc_word_t        expected_words[$];
    dir_row_t         dir_rows[$];
    int               mismatch_count = 0;
    int               quiet_cycles   = 0;
    int               send_idle_pct  = 0;
    int               recv_idle_pct  = 0;
    bit               hold_req       = 1'b0;

    base51_id_to_short_string_core #(
        .VALUE_WIDTH (ID_W)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #4 aclk = ~aclk;

    function automatic enc_word_t make_word(input logic [7:0] ch, input logic has,
                                            input logic [LEN_W-1:0] len, input logic fail,
                                            input logic last);
        enc_word_t w;
        w.symbol     = ch[SYMBOL_W-1:0];
        w.has_symbol = has;
        w.str_len    = len;
        w.failed     = fail;
        w.last       = last;
        return w;
    endfunction

    // Expected words for one ID under the current buffer capacity.
    task automatic predict_encoding(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] rem;
        logic [5:0]      digit_buf [DIGIT_SLOTS];
        int              n;
        int              k;
        rem = id;
        n   = 0;
        if (!id[ID_W-1]) begin
            while (rem != 0 && n < DIGIT_SLOTS) begin
                digit_buf[n] = 6'(rem % RADIX);
                rem          = rem / RADIX;
                n++;
            end
        end
        if (n >= int'(capacity_shadow) || n > MAX_DIGITS) begin
            expected_words.push_back(make_word(8'd0, 1'b0, 3'd0, 1'b1, 1'b1));
        end else if (n == 0) begin
            expected_words.push_back(make_word(8'd0, 1'b0, 3'd0, 1'b0, 1'b1));
        end else begin
            for (k = 0; k < n; k++) begin
                expected_words.push_back(make_word(symbol_set[digit_buf[n-1-k]], 1'b1,
                                                   LEN_W'(n), 1'b0, k == n - 1));
            end
        end
    endtask

    task automatic add_row(input logic [CAP_W-1:0] cap, input logic [ID_W-1:0] id,
                           input bit typed, input enc_word_t word);
        dir_row_t r;
        r.cap   = cap;
        r.id    = id;
        r.typed = typed;
        r.word  = word;
        dir_rows.push_back(r);
    endtask

    // Offer one ID until it is taken; valid stays high unless an idle burst follows.
    task automatic send_id(input logic [ID_W-1:0] id, input bit typed, input enc_word_t word);
        s_tdata  <= id;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (typed) begin
            expected_words.push_back(word);
        end else begin
            predict_encoding(id);
        end
        if ($urandom_range(1, 100) <= send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    // Capacity changes only once the block has nothing left in flight.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_wr_data <= cap;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en       <= 1'b0;
        capacity_shadow  = cap;
    endtask

    // Random ID, weighted toward each digit count and the digit-count boundaries.
    function automatic logic [ID_W-1:0] random_id();
        logic [ID_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: v = $urandom_range(0, 50);
            2: v = $urandom_range(51, 2600);
            3, 4: v = $urandom_range(32'h7FFF_FFFF, 345025251);
            5: v = $urandom_range(2601, 345025250);
            6: v = {1'b1, 31'($urandom)};
            7: begin
                case ($urandom_range(0, 13))
                    0: v = 32'd0;
                    1: v = 32'd1;
                    2: v = 32'd50;
                    3: v = 32'd51;
                    4: v = 32'd2600;
                    5: v = 32'd2601;
                    6: v = 32'd132650;
                    7: v = 32'd132651;
                    8: v = 32'd6765200;
                    9: v = 32'd6765201;
                    10: v = 32'd345025250;
                    11: v = 32'd345025251;
                    12: v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
            end
            default: v = $urandom & 32'h7FFF_FFFF;
        endcase
        return v;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Result side: compare every accepted word with the oldest expectation.
    always @(posedge aclk) begin
        enc_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got tdata %h tuser %b tlast %b",
                         $time, m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end else begin
                exp_w = expected_words.pop_front();
                check_field("symbol", 8'(exp_w.symbol), 8'(m_tdata[6:0]));
                check_field("string_length", 8'(exp_w.str_len), 8'(m_tdata[9:7]));
                check_field("has_symbol", 8'(exp_w.has_symbol), 8'(m_tuser[0]));
                check_field("failed", 8'(exp_w.failed), 8'(m_tuser[1]));
                check_field("last", 8'(exp_w.last), 8'(m_tlast));
            end
        end
    end

    // Receiver ready: short random stalls, or one long hold-off on request.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if ($urandom_range(1, 100) <= recv_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Watchdog: too long without any word moving on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        int p;
        int i;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        capacity_shadow = CAP_RESET;

        // Reset capacity: empty strings, single symbols and the longest IDs.
        add_row(8'd100, 32'd0,         1'b1, make_word(8'd0, 1'b0, 3'd0, 1'b0, 1'b1));
        add_row(8'd100, 32'hFFFF_FFFF, 1'b1, make_word(8'd0, 1'b0, 3'd0, 1'b0, 1'b1));
        add_row(8'd100, 32'h8000_0000, 1'b1, make_word(8'd0, 1'b0, 3'd0, 1'b0, 1'b1));
        add_row(8'd100, 32'd1,         1'b1, make_word("3", 1'b1, 3'd1, 1'b0, 1'b1));
        add_row(8'd100, 32'd50,        1'b1, make_word("_", 1'b1, 3'd1, 1'b0, 1'b1));
        add_row(8'd100, 32'd51,        1'b0, '0);
        add_row(8'd100, 32'd2601,      1'b0, '0);
        add_row(8'd100, 32'd345025250, 1'b0, '0);
        add_row(8'd100, 32'd345025251, 1'b0, '0);
        add_row(8'd100, 32'h7FFF_FFFF, 1'b0, '0);
        // Zero capacity fails even for an empty string.
        add_row(8'd0, 32'd0,           1'b1, make_word(8'd0, 1'b0, 3'd0, 1'b1, 1'b1));
        add_row(8'd0, 32'h8000_0000,   1'b1, make_word(8'd0, 1'b0, 3'd0, 1'b1, 1'b1));
        add_row(8'd0, 32'h7FFF_FFFF,   1'b1, make_word(8'd0, 1'b0, 3'd0, 1'b1, 1'b1));
        // Digit count just below and at the capacity.
        add_row(8'd1, 32'd0,           1'b1, make_word(8'd0, 1'b0, 3'd0, 1'b0, 1'b1));
        add_row(8'd1, 32'd1,           1'b1, make_word(8'd0, 1'b0, 3'd0, 1'b1, 1'b1));
        add_row(8'd2, 32'd50,          1'b1, make_word("_", 1'b1, 3'd1, 1'b0, 1'b1));
        add_row(8'd2, 32'd51,          1'b1, make_word(8'd0, 1'b0, 3'd0, 1'b1, 1'b1));
        add_row(8'd6, 32'h7FFF_FFFF,   1'b1, make_word(8'd0, 1'b0, 3'd0, 1'b1, 1'b1));
        add_row(8'd6, 32'd345025250,   1'b0, '0);
        add_row(8'd7, 32'h7FFF_FFFF,   1'b0, '0);
        // Largest capacity.
        add_row(8'd255, 32'h7FFF_FFFF, 1'b0, '0);
        add_row(8'd255, 32'h5555_5555, 1'b0, '0);
        add_row(8'd255, 32'hAAAA_AAAA, 1'b1, make_word(8'd0, 1'b0, 3'd0, 1'b0, 1'b1));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 20;
        recv_idle_pct = 20;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].cap != capacity_shadow) begin
                set_capacity(dir_rows[r].cap);
            end
            send_id(dir_rows[r].id, dir_rows[r].typed, dir_rows[r].word);
        end

        // Random phases, each under its own capacity and idle rates; the last has no idling.
        for (p = 0; p < RAND_PHASES; p++) begin
            if (p == 1 || $urandom_range(0, 3) == 0) begin
                set_capacity(8'($urandom_range(0, 7)));
            end else begin
                set_capacity(8'($urandom_range(7, 255)));
            end
            if (p == RAND_PHASES - 1) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = $urandom_range(0, 40);
                recv_idle_pct = $urandom_range(0, 40);
            end
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == 3) begin
                    hold_req = 1'b1;
                end
                if (p == 1 && i == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                send_id(random_id(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/b51_pkg.sv
rtl/b51_cell.sv
rtl/base51_id_to_short_string_core.sv
sim/tb_base51_id_to_short_string_core.sv
